### design/estk_pkg.sv
// Shared types and constants for the endpoint score top-k keeper.
package estk_pkg;

    localparam int IDX_W   = 4;
    localparam int SCORE_W = 3;
    localparam int TAG_W   = 16;
    localparam int FILL_W  = 5;
    localparam int DROP_W  = 16;

    localparam logic [SCORE_W-1:0] SCORE_LOOPBACK = 3'd0;
    localparam logic [SCORE_W-1:0] SCORE_V6       = 3'd1;
    localparam logic [SCORE_W-1:0] SCORE_PRIVATE  = 3'd2;
    localparam logic [SCORE_W-1:0] SCORE_PUBLIC   = 3'd3;
    localparam logic [SCORE_W-1:0] SCORE_LAN      = 3'd4;
    // Larger than any real score, so the first cell always takes the token.
    localparam logic [SCORE_W-1:0] SCORE_NONE     = 3'd7;

    localparam logic ACTION_CLEAR = 1'b0;
    localparam logic ACTION_OFFER = 1'b1;

    localparam logic REG_LOCAL_ADDRESS = 1'b0;
    localparam logic REG_LOCAL_PREFIX  = 1'b1;

    typedef struct packed {
        logic             action;
        logic             is_ipv4;
        logic [7:0]       octet_a;
        logic [7:0]       octet_b;
        logic [7:0]       octet_c;
        logic [7:0]       octet_d;
        logic [TAG_W-1:0] endpoint_tag;
    } in_item_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               kept;
        logic [IDX_W-1:0]   slot_index;
        logic               evicted_valid;
        logic [TAG_W-1:0]   evicted_tag;
        logic [FILL_W-1:0]  filled_count;
        logic [DROP_W-1:0]  dropped_total;
    } out_item_t;

    // Scan token: the weakest slot seen so far along the chain.
    typedef struct packed {
        logic               valid;
        logic [SCORE_W-1:0] score;
        logic [IDX_W-1:0]   idx;
        logic [TAG_W-1:0]   tag;
    } tok_t;

    // Slot write broadcast to every cell.
    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   idx;
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
    } wr_t;

endpackage

### design/estk_scorer.sv
// Endpoint scoring logic: loopback, local subnet, private ranges, public, IPv6.
module estk_scorer (
    input  estk_pkg::in_item_t              item,
    input  logic [31:0]                     local_address,
    input  logic [5:0]                      local_prefix,
    output logic [estk_pkg::SCORE_W-1:0]    score
);

    logic [31:0] addr;
    logic [4:0]  shamt;
    logic [31:0] mask;
    logic        prefix_ok;
    logic        in_subnet;
    logic        is_private;

    always_comb
    begin
        addr      = {item.octet_a, item.octet_b, item.octet_c, item.octet_d};
        prefix_ok = (local_prefix != 6'd0) && (local_prefix <= 6'd32);
        shamt     = 5'(6'd32 - local_prefix);
        mask      = 32'hFFFF_FFFF << shamt;
        in_subnet = prefix_ok && ((addr & mask) == (local_address & mask));

        is_private = (item.octet_a == 8'd10)
                  || (item.octet_a == 8'd192 && item.octet_b == 8'd168)
                  || (item.octet_a == 8'd172 && item.octet_b >= 8'd16
                      && item.octet_b <= 8'd31)
                  || (item.octet_a == 8'd169 && item.octet_b == 8'd254)
                  || (item.octet_a == 8'd100 && item.octet_b >= 8'd64
                      && item.octet_b <= 8'd127);

        if (!item.is_ipv4)
            score = estk_pkg::SCORE_V6;
        else if (item.octet_a == 8'd127)
            score = estk_pkg::SCORE_LOOPBACK;
        else if (in_subnet)
            score = estk_pkg::SCORE_LAN;
        else if (is_private)
            score = estk_pkg::SCORE_PRIVATE;
        else
            score = estk_pkg::SCORE_PUBLIC;
    end

endmodule

### design/estk_cell.sv
// One slot cell: holds a score and tag, and passes the weakest-slot token on.
module estk_cell #(
    parameter int CELL_ID = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  estk_pkg::wr_t  wr,
    input  estk_pkg::tok_t tok_in,
    output estk_pkg::tok_t tok_out
);

    logic [estk_pkg::SCORE_W-1:0] score_reg;
    logic [estk_pkg::TAG_W-1:0]   tag_reg;
    logic                         tok_valid_reg;
    estk_pkg::tok_t               tok_reg;
    estk_pkg::tok_t               tok_next;

    always_ff @(posedge clk)
    begin
        if (wr.en && wr.idx == estk_pkg::IDX_W'(CELL_ID))
        begin
            score_reg <= wr.score;
            tag_reg   <= wr.tag;
        end
    end

    // Only a strictly lower score takes over, so the first lowest slot wins.
    always_comb
    begin
        tok_next = tok_in;
        if (score_reg < tok_in.score)
        begin
            tok_next.score = score_reg;
            tok_next.idx   = estk_pkg::IDX_W'(CELL_ID);
            tok_next.tag   = tag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_valid_reg <= 1'b0;
        else
            tok_valid_reg <= tok_in.valid;
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = tok_valid_reg;
    end

endmodule

### design/endpoint_score_topk_keeper.sv
// Top level of the endpoint score top-k keeper: control, counters and the slot cell chain.
//
// Usage: the input channel (in_valid, in_stall, in_data) carries one item per
// handshake; an item is either a clear (action 0) that starts a new peer, or
// an endpoint offer (action 1). Every item yields exactly one result item on
// the output channel (out_valid, out_stall, out_data) with the endpoint's
// score, where it was stored, which endpoint it evicted and the counters.
// Configuration (local_address, local_prefix) is written through cfg_we,
// cfg_index and cfg_data while the block is idle.
// Flow: a clear, a loopback offer or an offer into a free slot passes through
// the EVAL and FINISH states before it reaches out_valid; an offer into a full
// table also sends a token down the row of SLOTS cells in the SCAN state to
// find the first weakest slot. One item is worked on at a time, and the next
// is taken only once a result has been issued and the block is idle again.
// Reset clears the fill count, the drop counter, the configuration and all
// handshake state; slot contents are not cleared and are only read once all
// slots have been written. When the receiver stalls, the finished result
// waits in the output register; one more item may be accepted and computed
// meanwhile, and it then waits until the output register frees up.
module endpoint_score_topk_keeper #(
    parameter int SLOTS = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  estk_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output estk_pkg::out_item_t out_data
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EVAL   = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]                      state_reg;
    logic [1:0]                      state_next;
    logic [31:0]                     local_address_reg;
    logic [5:0]                      local_prefix_reg;
    estk_pkg::in_item_t              item_reg;
    logic [estk_pkg::SCORE_W-1:0]    score_reg;
    logic [estk_pkg::SCORE_W-1:0]    score_next;
    logic [estk_pkg::FILL_W-1:0]     occupied_reg;
    logic [estk_pkg::FILL_W-1:0]     occupied_next;
    logic [estk_pkg::DROP_W-1:0]     drop_reg;
    logic [estk_pkg::DROP_W-1:0]     drop_next;
    estk_pkg::out_item_t             res_reg;
    estk_pkg::out_item_t             res_next;
    estk_pkg::out_item_t             out_reg;
    logic                            out_valid_reg;
    logic [estk_pkg::SCORE_W-1:0]    item_score;
    logic [estk_pkg::DROP_W-1:0]     drop_inc;
    logic                            out_free;
    estk_pkg::wr_t                   wr;
    estk_pkg::tok_t                  tok_head;
    estk_pkg::tok_t                  tok [SLOTS+1];

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign drop_inc  = (drop_reg != 16'hFFFF) ? drop_reg + 16'd1 : drop_reg;
    assign tok[0]    = tok_head;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_address_reg <= '0;
            local_prefix_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                estk_pkg::REG_LOCAL_ADDRESS: local_address_reg <= cfg_data;
                estk_pkg::REG_LOCAL_PREFIX:  local_prefix_reg  <= cfg_data[5:0];
                default:                     local_address_reg <= local_address_reg;
            endcase
        end
    end

    estk_scorer u_scorer (
        .item          (item_reg),
        .local_address (local_address_reg),
        .local_prefix  (local_prefix_reg),
        .score         (item_score)
    );

    // The row of slot cells; the token enters at cell 0 and leaves at the end.
    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            estk_cell #(
                .CELL_ID (g)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .wr      (wr),
                .tok_in  (tok[g]),
                .tok_out (tok[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        score_next     = score_reg;
        occupied_next  = occupied_reg;
        drop_next      = drop_reg;
        res_next       = res_reg;
        wr             = '0;
        tok_head       = '0;
        tok_head.score = estk_pkg::SCORE_NONE;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_EVAL;
            end

            S_EVAL:
            begin
                res_next       = '0;
                score_next     = item_score;
                res_next.score = item_score;
                state_next     = S_FINISH;
                if (item_reg.action == estk_pkg::ACTION_CLEAR)
                begin
                    res_next.score = estk_pkg::SCORE_LOOPBACK;
                    occupied_next  = '0;
                    drop_next      = '0;
                end
                else if (item_score == estk_pkg::SCORE_LOOPBACK)
                begin
                    res_next.filled_count  = occupied_reg;
                    res_next.dropped_total = drop_reg;
                end
                else if (occupied_reg < estk_pkg::FILL_W'(SLOTS))
                begin
                    wr.en                  = 1'b1;
                    wr.idx                 = occupied_reg[estk_pkg::IDX_W-1:0];
                    wr.score               = item_score;
                    wr.tag                 = item_reg.endpoint_tag;
                    occupied_next          = occupied_reg + 5'd1;
                    res_next.kept          = 1'b1;
                    res_next.slot_index    = occupied_reg[estk_pkg::IDX_W-1:0];
                    res_next.filled_count  = occupied_reg + 5'd1;
                    res_next.dropped_total = drop_reg;
                end
                else
                begin
                    // Full table: walk the cells to find the weakest slot.
                    tok_head.valid = 1'b1;
                    state_next     = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (tok[SLOTS].valid)
                begin
                    drop_next              = drop_inc;
                    res_next.filled_count  = occupied_reg;
                    res_next.dropped_total = drop_inc;
                    if (tok[SLOTS].score < score_reg)
                    begin
                        wr.en                  = 1'b1;
                        wr.idx                 = tok[SLOTS].idx;
                        wr.score               = score_reg;
                        wr.tag                 = item_reg.endpoint_tag;
                        res_next.kept          = 1'b1;
                        res_next.slot_index    = tok[SLOTS].idx;
                        res_next.evicted_valid = 1'b1;
                        res_next.evicted_tag   = tok[SLOTS].tag;
                    end
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occupied_reg  <= '0;
            drop_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            occupied_reg <= occupied_next;
            drop_reg     <= drop_next;
            if (state_reg == S_FINISH && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
            item_reg <= in_data;
        score_reg <= score_next;
        res_reg   <= res_next;
        if (state_reg == S_FINISH && out_free)
            out_reg <= res_reg;
    end

endmodule
